>>> rtl/core/wss_pkg.sv
// Shared types and constants for the weighted symbol sampler.
// Holds the request/response words, command and status codes.
// No dependencies.
package wss_pkg;

  // Default table size and cumulative-sum width
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int SUM_WIDTH_DEF   = 32;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int SYM_W    = 8;
  localparam int WEIGHT_W = 24;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [SYM_W-1:0]    symbol;
    logic [WEIGHT_W-1:0] weight;
    logic [KEY_W-1:0]    random_key;
  } req_word_t;

  typedef struct packed {
    logic [SYM_W-1:0] chosen_symbol;
    status_e          status;
  } rsp_word_t;

endpackage

>>> rtl/core/wss_if.sv
// Valid/ready channel interfaces for the weighted symbol sampler.
// Depends on wss_pkg for the word types.
interface wss_req_if;
  import wss_pkg::*;
  logic      valid;
  logic      ready;
  req_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface wss_rsp_if;
  import wss_pkg::*;
  logic      valid;
  logic      ready;
  rsp_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/wss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/wss_cell.sv
// One search cell: decides one bit of the table index for a sample.
// Holds the cumulative sums of the entries probed at its level.
// Depends on wss_pkg and wss_ram.
module wss_cell #(
  parameter int MAX_ENTRIES = 256,
  parameter int SUM_WIDTH   = 32,
  parameter int LEVEL       = 0,
  parameter int IW          = $clog2(MAX_ENTRIES),
  parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // table append
  input  logic                       wr_en_i,
  input  logic [IW-1:0]              wr_idx_i,
  input  logic [SUM_WIDTH-1:0]       wr_sum_i,
  input  logic [CW-1:0]              count_i,
  // search word from the upstream neighbor
  input  logic                       valid_i,
  input  logic [IW-1:0]              pos_i,
  input  logic [wss_pkg::KEY_W-1:0]  key_i,
  // search word to the downstream neighbor
  output logic                       valid_o,
  output logic [IW-1:0]              pos_o,
  output logic [wss_pkg::KEY_W-1:0]  key_o
);
  import wss_pkg::*;

  // Entries probed here are those whose index has exactly LEVEL trailing ones
  localparam int Depth = ((MAX_ENTRIES - 1) >> (LEVEL + 1)) + 1;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CmpW  = (SUM_WIDTH > KEY_W) ? SUM_WIDTH : KEY_W;
  localparam int PW    = IW + 1;
  localparam logic [IW-1:0] LowMask = IW'((1 << (LEVEL + 1)) - 1);
  localparam logic [IW-1:0] Pattern = IW'((1 << LEVEL) - 1);
  localparam logic [PW-1:0] Step    = PW'(1 << LEVEL);

  logic                 valid_q;
  logic [IW-1:0]        pos_q;
  logic [KEY_W-1:0]     key_q;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [AddrW-1:0]     ram_raddr;
  logic [SUM_WIDTH-1:0] cum;
  logic [PW-1:0]        probe;
  logic                 in_range;
  logic                 below_key;

  // Store an appended sum only if its index belongs to this level
  assign ram_we    = wr_en_i && ((wr_idx_i & LowMask) == Pattern);
  assign ram_waddr = AddrW'(wr_idx_i >> (LEVEL + 1));
  assign ram_raddr = AddrW'(pos_i >> (LEVEL + 1));

  wss_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (Depth)
  ) u_sum_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (wr_sum_i),
    .rd_addr_i (ram_raddr),
    .rd_data_o (cum)
  );

  // Capture the search word alongside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_i;
    key_q <= key_i;
  end

  // Advance past the probed entry when it lies in the table and is below the key
  assign probe     = PW'(pos_q) + Step;
  assign in_range  = probe <= PW'(count_i);
  assign below_key = CmpW'(cum) < CmpW'(key_q);

  assign valid_o = valid_q;
  assign pos_o   = (in_range && below_key) ? probe[IW-1:0] : pos_q;
  assign key_o   = key_q;

endmodule

>>> rtl/core/weighted_symbol_sampler_top.sv
// Weighted symbol sampler: table of byte symbols with cumulative weights.
// Depends on wss_pkg, wss_if, wss_cell and wss_ram.
//
// Usage
//   req_i carries one command word: clear the table, append a symbol with a
//   weight, or sample with a key in 1..total. rsp_o returns exactly one word
//   per command: the chosen symbol (zero unless a sample succeeds) and a
//   status (ok, key out of range or empty table, sum overflow, table full).
//   The block works on one command at a time; req_i.ready is high while it
//   is free, also while a finished word still waits in the output register.
//   Clear, append, unused commands and rejected samples pass through the
//   result register and then the output register; the next command is taken
//   only once that word has moved on. A valid sample runs through a chain of
//   log2(MAX_ENTRIES) search cells, each cell reading its own sum memory and
//   handing position and key to its neighbor, then the symbol memory read,
//   the result register and the output register; here too the next command
//   waits until the word reaches the output register.
//   If rsp_o is stalled, the finished word is held; one more command is taken
//   and worked, then waits until the output register frees up.
//   Reset empties the table and drops any pending word; the memories need
//   no clearing since only appended entries are ever searched.
module weighted_symbol_sampler_top #(
  parameter int MAX_ENTRIES = wss_pkg::MAX_ENTRIES_DEF,
  parameter int SUM_WIDTH   = wss_pkg::SUM_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wss_req_if.sink     req_i,
  wss_rsp_if.source   rsp_o
);
  import wss_pkg::*;

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (SUM_WIDTH > KEY_W) ? SUM_WIDTH : KEY_W;
  localparam int AddW = ((SUM_WIDTH > WEIGHT_W) ? SUM_WIDTH : WEIGHT_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUSY = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [SUM_WIDTH-1:0] total_q, total_d;
  rsp_word_t            res_q, res_d;
  rsp_word_t            out_q;
  logic                 out_valid_q, out_valid_d;
  logic                 load_out;
  logic                 sym_valid_q;
  logic                 accept;
  logic                 wr_en;
  logic                 start;
  logic [AddW-1:0]      sum;
  logic                 sum_ovf;
  logic                 key_bad;
  logic [SYM_W-1:0]     sym_rd;

  // Search words between neighboring cells; index IW enters the chain
  logic                 valid_s [IW+1];
  logic [IW-1:0]        pos_s   [IW+1];
  logic [KEY_W-1:0]     key_s   [IW+1];

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // Append arithmetic and sample key check
  assign sum     = AddW'(total_q) + AddW'(req_i.payload.weight);
  assign sum_ovf = |sum[AddW-1:SUM_WIDTH];
  assign key_bad = (count_q == '0) || (req_i.payload.random_key == '0) ||
                   (CmpW'(req_i.payload.random_key) > CmpW'(total_q));

  // Command decode and sequencing
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    total_d  = total_q;
    res_d    = res_q;
    wr_en    = 1'b0;
    start    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.chosen_symbol = '0;
          res_d.status        = ST_OK;
          state_d             = S_HOLD;
          case (req_i.payload.command)
            CMD_CLEAR: begin
              count_d = '0;
              total_d = '0;
            end
            CMD_APPEND: begin
              if (req_i.payload.weight != '0) begin
                if (count_q == CW'(MAX_ENTRIES)) begin
                  res_d.status = ST_FULL;
                end else if (sum_ovf) begin
                  res_d.status = ST_OVERFLOW;
                end else begin
                  wr_en   = 1'b1;
                  total_d = sum[SUM_WIDTH-1:0];
                  count_d = count_q + CW'(1);
                end
              end
            end
            CMD_SAMPLE: begin
              if (key_bad) begin
                res_d.status = ST_RANGE;
              end else begin
                start   = 1'b1;
                state_d = S_BUSY;
              end
            end
            default: ;
          endcase
        end
      end
      S_BUSY: begin
        if (sym_valid_q) begin
          res_d.chosen_symbol = sym_rd;
          state_d             = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: hold until taken, reload when free
  assign out_valid_d = load_out || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      sym_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      sym_valid_q <= valid_s[0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // Feed the head of the cell chain
  assign valid_s[IW] = start;
  assign pos_s[IW]   = '0;
  assign key_s[IW]   = req_i.payload.random_key;

  // Cell chain, most significant index bit first
  for (genvar b = IW - 1; b >= 0; b--) begin : g_cell
    wss_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .SUM_WIDTH   (SUM_WIDTH),
      .LEVEL       (b)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (wr_en),
      .wr_idx_i (count_q[IW-1:0]),
      .wr_sum_i (sum[SUM_WIDTH-1:0]),
      .count_i  (count_q),
      .valid_i  (valid_s[b+1]),
      .pos_i    (pos_s[b+1]),
      .key_i    (key_s[b+1]),
      .valid_o  (valid_s[b]),
      .pos_o    (pos_s[b]),
      .key_o    (key_s[b])
    );
  end

  // Symbol memory, read at the index the chain settles on
  wss_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_sym_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IW-1:0]),
    .wr_data_i (req_i.payload.symbol),
    .rd_addr_i (pos_s[0]),
    .rd_data_o (sym_rd)
  );

endmodule

>>> verif/tb_weighted_symbol_sampler_top.sv
`timescale 1ns / 100ps
// Self-checking bench for weighted_symbol_sampler_top: directed and random command words,
// predicted results compared field by field. Depends on wss_pkg, wss_req_if and wss_rsp_if.
module tb_weighted_symbol_sampler_top;
  import wss_pkg::*;

  localparam int TBL_DEPTH = MAX_ENTRIES_DEF;
  localparam longint SUM_MAX = (longint'(1) << SUM_WIDTH_DEF) - 1;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1150;
  localparam int DRAIN_CYCLES = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  wss_req_if req_if ();
  wss_rsp_if rsp_if ();

  weighted_symbol_sampler_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Words waiting to be sent, and picks/statuses still owed by the block
  req_word_t pending_words[$];
  rsp_word_t owed_picks[$];
  rsp_word_t due_pick;
  int fail_count = 0;
  int cycle_no = 0;

  // Predicted symbol table
  logic [SUM_WIDTH_DEF-1:0] cum_weight [TBL_DEPTH];
  logic [SYM_W-1:0]         sym_entry  [TBL_DEPTH];
  int                       entry_cnt = 0;
  longint                   weight_sum = 0;

  // Fill level and total as the stimulus side sees them, for choosing keys
  int     gen_cnt = 0;
  longint gen_sum = 0;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
  end

  // Idle on about 6 rolls in a hundred, except in a long window of each period where it never idles
  function automatic bit idle_roll();
    if ((cycle_no % 6000) >= 4000) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  // Update the predicted table for one accepted word and queue its pick and status
  function automatic void predict_pick(input req_word_t w);
    rsp_word_t r;
    int lo;
    int hi;
    int mid;
    r.chosen_symbol = '0;
    r.status = ST_OK;
    case (w.command)
      CMD_CLEAR: begin
        entry_cnt = 0;
        weight_sum = 0;
      end
      CMD_APPEND: begin
        if (w.weight != 0) begin
          if (entry_cnt >= TBL_DEPTH) begin
            r.status = ST_FULL;
          end else if (longint'(w.weight) > SUM_MAX - weight_sum) begin
            r.status = ST_OVERFLOW;
          end else begin
            weight_sum += longint'(w.weight);
            cum_weight[entry_cnt] = weight_sum[SUM_WIDTH_DEF-1:0];
            sym_entry[entry_cnt] = w.symbol;
            entry_cnt++;
          end
        end
      end
      CMD_SAMPLE: begin
        if (entry_cnt == 0 || w.random_key == 0 || longint'(w.random_key) > weight_sum) begin
          r.status = ST_RANGE;
        end else begin
          // first entry whose running total reaches the key
          lo = 0;
          hi = entry_cnt - 1;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (cum_weight[mid] >= w.random_key) hi = mid;
            else lo = mid + 1;
          end
          r.chosen_symbol = sym_entry[lo];
        end
      end
      default: ;
    endcase
    owed_picks.push_back(r);
  endfunction

  // Queue one command word and track fill level and total for key choice
  function automatic void queue_word(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                                     input logic [WEIGHT_W-1:0] wgt,
                                     input logic [KEY_W-1:0] key);
    req_word_t w;
    w.command = cmd;
    w.symbol = sym;
    w.weight = wgt;
    w.random_key = key;
    pending_words.push_back(w);
    if (cmd == CMD_CLEAR) begin
      gen_cnt = 0;
      gen_sum = 0;
    end else if (cmd == CMD_APPEND && wgt != 0 && gen_cnt < TBL_DEPTH &&
                 longint'(wgt) <= SUM_MAX - gen_sum) begin
      gen_cnt++;
      gen_sum += longint'(wgt);
    end
  endfunction

  // Mostly keys in range, with the edges and out-of-range keys mixed in
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (gen_sum == 0 || r >= 94) return $urandom;
    if (r < 75) return $urandom_range(32'(gen_sum), 1);
    if (r < 81) return 32'(gen_sum);
    if (r < 85) return 32'd1;
    if (r < 89) return 32'd0;
    return 32'(gen_sum + 1);
  endfunction

  // Hold until every queued word is sent and every pick has come back
  task automatic wait_drained();
    while (pending_words.size() != 0 || owed_picks.size() != 0 || req_if.valid)
      @(negedge clk_i);
  endtask

  // Request driver: hold a word until taken, then advance to the next
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
    end else begin
      if (req_if.valid && req_if.ready) predict_pick(req_if.payload);
      if (!req_if.valid || req_if.ready) begin
        if (pending_words.size() != 0 && !idle_roll()) begin
          req_if.valid <= 1'b1;
          req_if.payload <= pending_words.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken word with the oldest owed pick, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (owed_picks.size() == 0) begin
          $display("%0t: result with none owed: expected nothing, actual symbol %0h status %0d",
                   $realtime, rsp_if.payload.chosen_symbol, rsp_if.payload.status);
          fail_count++;
        end else begin
          due_pick = owed_picks.pop_front();
          if (rsp_if.payload.chosen_symbol !== due_pick.chosen_symbol) begin
            $display("%0t: chosen_symbol mismatch: expected %0h, actual %0h", $realtime,
                     due_pick.chosen_symbol, rsp_if.payload.chosen_symbol);
            fail_count++;
          end
          if (rsp_if.payload.status !== due_pick.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $realtime,
                     due_pick.status, rsp_if.payload.status);
            fail_count++;
          end
        end
      end
      rsp_if.ready <= !idle_roll();
    end
  end

  initial begin
    int fill_no;
    int steps;
    int wmode;
    int r;
    int random_words;
    logic [WEIGHT_W-1:0] wgt;
    rst_ni = 1'b0;

    // Directed: empty table, unused command, zero weight, edges of the key range
    queue_word(CMD_SAMPLE, 8'h11, 24'd0, 32'd5);
    queue_word(CMD_UNUSED, 8'h00, 24'd0, 32'd0);
    queue_word(CMD_APPEND, 8'hFF, 24'd0, 32'd0);
    queue_word(CMD_APPEND, 8'hA5, 24'd1, 32'd0);
    queue_word(CMD_APPEND, 8'h00, 24'hFFFFFF, 32'd0);
    queue_word(CMD_APPEND, 8'h5A, 24'd100, 32'd0);
    queue_word(CMD_SAMPLE, 8'h00, 24'd0, 32'd0);
    queue_word(CMD_SAMPLE, 8'h00, 24'd0, 32'd1);
    queue_word(CMD_SAMPLE, 8'h00, 24'd0, 32'd2);
    queue_word(CMD_SAMPLE, 8'h00, 24'd0, 32'(gen_sum));
    queue_word(CMD_SAMPLE, 8'h00, 24'd0, 32'(gen_sum + 1));
    queue_word(CMD_SAMPLE, 8'h00, 24'd0, 32'hFFFFFFFF);
    queue_word(CMD_CLEAR, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF);
    queue_word(CMD_SAMPLE, 8'h00, 24'd0, 32'd1);
    queue_word(CMD_APPEND, 8'h3C, 24'd50, 32'd0);
    queue_word(CMD_APPEND, 8'hC3, 24'd7, 32'd0);
    // key below the first weight lands on the first entry
    queue_word(CMD_SAMPLE, 8'h00, 24'd0, 32'd7);
    queue_word(CMD_SAMPLE, 8'h00, 24'd0, 32'd51);
    queue_word(CMD_UNUSED, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF);
    queue_word(CMD_SAMPLE, 8'hFF, 24'hFFFFFF, 32'd57);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Hold the sender until the directed words have all come back
    wait_drained();

    random_words = 0;
    fill_no = 0;
    while (random_words < RANDOM_WORDS) begin
      if (fill_no == 0 || $urandom_range(15) == 0) begin
        // Fill the table to the brim; the first fill uses the heaviest weight
        queue_word(CMD_CLEAR, 8'($urandom_range(255)), 24'($urandom), $urandom);
        while (gen_cnt < TBL_DEPTH) begin
          if ($urandom_range(7) == 0) begin
            queue_word(CMD_SAMPLE, 8'($urandom_range(255)), 24'($urandom), pick_key());
          end else begin
            wgt = (fill_no == 0) ? 24'hFFFFFF : 24'($urandom_range(24'hFFFFFF, 24'hF00000));
            queue_word(CMD_APPEND, 8'($urandom_range(255)), wgt, $urandom);
          end
          random_words++;
        end
        // full table rejects further weights, zero weight still passes quietly
        queue_word(CMD_APPEND, 8'($urandom_range(255)), 24'hFFFFFF, $urandom);
        queue_word(CMD_APPEND, 8'($urandom_range(255)), 24'd1, $urandom);
        queue_word(CMD_APPEND, 8'($urandom_range(255)), 24'd0, $urandom);
        repeat (12) queue_word(CMD_SAMPLE, 8'($urandom_range(255)), 24'($urandom), pick_key());
        random_words += 14;
        fill_no++;
      end else begin
        // Short table built and searched, often from a fresh clear
        if ($urandom_range(3) != 0) begin
          queue_word(CMD_CLEAR, 8'($urandom_range(255)), 24'($urandom), $urandom);
          random_words++;
        end
        wmode = $urandom_range(2);
        steps = $urandom_range(40, 4);
        repeat (steps) begin
          r = $urandom_range(99);
          if (r < 45) begin
            case (wmode)
              0: wgt = 24'($urandom_range(15, 1));
              1: wgt = 24'($urandom_range(65535, 1));
              default: wgt = 24'($urandom_range(24'hFFFFFF, 1));
            endcase
            queue_word(CMD_APPEND, 8'($urandom_range(255)), wgt, $urandom);
            random_words++;
          end else if (r < 91) begin
            queue_word(CMD_SAMPLE, 8'($urandom_range(255)), 24'($urandom), pick_key());
            random_words++;
          end else if (r < 94) begin
            queue_word(CMD_APPEND, 8'($urandom_range(255)), 24'd0, $urandom);
          end else if (r < 97) begin
            queue_word(CMD_UNUSED, 8'($urandom_range(255)), 24'($urandom), $urandom);
          end else begin
            queue_word(CMD_CLEAR, 8'($urandom_range(255)), 24'($urandom), $urandom);
            random_words++;
          end
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && owed_picks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
